FILE: rtl/core/preemptive_priority_scheduler_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the preemptive priority scheduler
// Implication checks on the block's clock with reset masking.
// ----------------------------------------------------------------------------
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_MACROS_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_MACROS_SVH

// Same-cycle implication: when ante holds, cons holds in the same cycle.
`define PPS_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: when ante holds, cons holds in the next cycle.
`define PPS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/pps_pkg.sv
// ----------------------------------------------------------------------------
// pps_pkg
// Constants, table entry type, controller states and command/status groups.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pps_pkg;

  localparam int READY_DEPTH = 8;
  localparam int PRIO_LEVELS = 7;

  localparam int IDX_W   = $clog2(READY_DEPTH);
  localparam int CNT_W   = $clog2(READY_DEPTH + 1);
  localparam int ID_W    = 8;
  localparam int PRIO_W  = 3;
  localparam int LEFT_W  = 8;
  localparam int COUNT_W = 4;
  localparam int QUANT_W = 8;

  localparam logic [QUANT_W-1:0] QUANTUM_RESET = 8'd3;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
    logic [LEFT_W-1:0] left;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_SHIFT,
    ST_COMMIT,
    ST_REPORT
  } state_t;

  typedef struct packed {
    logic take;
    logic start;
    logic scan_step;
    logic shift_start;
    logic shift_step;
    logic commit;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic dispatch;
    logic shift_done;
    logic out_free;
  } sts_t;

endpackage

FILE: rtl/core/pps_if.sv
// ----------------------------------------------------------------------------
// pps_if
// Tick, result and configuration channels, each with valid/ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pps_tick_if import pps_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              mode;
  logic [ID_W-1:0]   task_id;
  logic [PRIO_W-1:0] priority_req;

  modport source (output valid, mode, task_id, priority_req, input ready);
  modport sink   (input valid, mode, task_id, priority_req, output ready);
endinterface

interface pps_sched_if import pps_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               running_valid;
  logic [ID_W-1:0]    running_id;
  logic [PRIO_W-1:0]  running_priority;
  logic [LEFT_W-1:0]  running_left;
  logic               preempted;
  logic               retired;
  logic [COUNT_W-1:0] ready_count;
  logic               admit_dropped;

  modport source (output valid, running_valid, running_id, running_priority,
                  running_left, preempted, retired, ready_count, admit_dropped,
                  input ready);
  modport sink   (input valid, running_valid, running_id, running_priority,
                  running_left, preempted, retired, ready_count, admit_dropped,
                  output ready);
endinterface

interface pps_cfg_if import pps_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [QUANT_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

FILE: rtl/core/pps_ctrl.sv
// ----------------------------------------------------------------------------
// pps_ctrl
// Tick sequencer: accept, scan, decide, compact, commit, report.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pps_ctrl import pps_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic tick_valid,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (tick_valid) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.scan_done) state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        state_next = sts.dispatch ? ST_SHIFT : ST_COMMIT;
      end
      ST_SHIFT: begin
        if (sts.shift_done) state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        state_next = ST_REPORT;
      end
      ST_REPORT: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE: begin
        cmd.take  = 1'b1;
        cmd.start = tick_valid;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
      end
      ST_DECIDE: begin
        cmd.shift_start = sts.dispatch;
      end
      ST_SHIFT: begin
        cmd.shift_step = 1'b1;
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
      end
      ST_REPORT: begin
        cmd.load_out = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

FILE: rtl/core/pps_datapath.sv
// ----------------------------------------------------------------------------
// pps_datapath
// Ready table memory, running slot, best-entry scan and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pps_datapath import pps_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output sts_t        sts,
  pps_tick_if.sink    tick,
  pps_sched_if.source sched,
  pps_cfg_if.sink     cfg
);

  // ready table, one read and one write port, registered read
  entry_t mem [READY_DEPTH];
  entry_t rd_data;

  logic [QUANT_W-1:0] quantum;
  logic [CNT_W-1:0]   used;

  logic              run_valid;
  logic [ID_W-1:0]   run_id;
  logic [PRIO_W-1:0] run_prio;
  logic [LEFT_W-1:0] run_left;

  logic retired_f;
  logic dropped_f;
  logic preempted_f;

  logic [CNT_W-1:0] scan_ptr;
  logic             cmp_valid;
  logic [IDX_W-1:0] cmp_idx;
  logic             found;
  logic [IDX_W-1:0] best_idx;
  entry_t           best;

  logic [CNT_W-1:0] sh_ptr;
  logic             sh_valid;
  logic [IDX_W-1:0] sh_waddr;

  logic               res_valid;
  logic               res_running_valid;
  logic [ID_W-1:0]    res_running_id;
  logic [PRIO_W-1:0]  res_running_priority;
  logic [LEFT_W-1:0]  res_running_left;
  logic               res_preempted;
  logic               res_retired;
  logic [COUNT_W-1:0] res_ready_count;
  logic               res_admit_dropped;

  logic [PRIO_W-1:0] prio_clamped;
  logic              table_full;
  logic              push_ok;
  logic              do_dispatch;
  logic              do_preempt;
  logic [CNT_W-1:0]  used_m1;
  logic [CNT_W-1:0]  sh_ptr_m1;
  logic              scan_rd;
  logic              shift_rd;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  entry_t            mem_wdata;
  logic              mem_re;
  logic [IDX_W-1:0]  mem_raddr;
  logic [LEFT_W-1:0] commit_left;
  logic              commit_valid;

  // clamp the admitted priority into the legal range
  always_comb begin
    prio_clamped = tick.priority_req;
    if (tick.priority_req == '0) begin
      prio_clamped = PRIO_W'(1);
    end else if (tick.priority_req > PRIO_W'(PRIO_LEVELS)) begin
      prio_clamped = PRIO_W'(PRIO_LEVELS);
    end
  end

  assign table_full  = (used == CNT_W'(READY_DEPTH));
  assign push_ok     = cmd.start && tick.mode && !table_full;
  assign do_dispatch = found && (!run_valid || (best.prio < run_prio));
  assign do_preempt  = do_dispatch && run_valid;
  assign used_m1     = used - CNT_W'(1);
  assign sh_ptr_m1   = sh_ptr - CNT_W'(1);
  assign scan_rd     = cmd.scan_step && (scan_ptr < used);
  assign shift_rd    = cmd.shift_step && (sh_ptr < used);

  // write port: admit push, compaction move, or push-back of a preempted task
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = used[IDX_W-1:0];
    mem_wdata = rd_data;
    if (push_ok) begin
      mem_we    = 1'b1;
      mem_waddr = used[IDX_W-1:0];
      mem_wdata = '{id: tick.task_id, prio: prio_clamped, left: quantum};
    end else if (sh_valid) begin
      mem_we    = 1'b1;
      mem_waddr = sh_waddr;
      mem_wdata = rd_data;
    end else if (cmd.commit && do_preempt) begin
      mem_we    = 1'b1;
      mem_waddr = used_m1[IDX_W-1:0];
      mem_wdata = '{id: run_id, prio: run_prio, left: run_left};
    end
  end

  always_comb begin
    mem_re    = scan_rd || shift_rd;
    mem_raddr = shift_rd ? sh_ptr[IDX_W-1:0] : scan_ptr[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
    end
  end

  // running task after dispatch, then decremented with saturation at zero
  always_comb begin
    commit_valid = do_dispatch || run_valid;
    commit_left  = do_dispatch ? best.left : run_left;
    if (commit_valid && (commit_left != '0)) begin
      commit_left = commit_left - LEFT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quantum     <= QUANTUM_RESET;
      used        <= '0;
      run_valid   <= 1'b0;
      run_id      <= '0;
      run_prio    <= '0;
      run_left    <= '0;
      retired_f   <= 1'b0;
      dropped_f   <= 1'b0;
      preempted_f <= 1'b0;
      scan_ptr    <= '0;
      cmp_valid   <= 1'b0;
      found       <= 1'b0;
      sh_ptr      <= '0;
      sh_valid    <= 1'b0;
      res_valid   <= 1'b0;
    end else begin
      if (cfg.valid) begin
        quantum <= cfg.data;
      end

      if (cmd.start) begin
        dropped_f   <= tick.mode && table_full;
        preempted_f <= 1'b0;
        scan_ptr    <= '0;
        cmp_valid   <= 1'b0;
        found       <= 1'b0;
        if (push_ok) begin
          used <= used + CNT_W'(1);
        end
        // retire a task whose time has run out
        if (run_valid && (run_left == '0)) begin
          run_valid <= 1'b0;
          retired_f <= 1'b1;
        end else begin
          retired_f <= 1'b0;
        end
      end

      if (cmd.scan_step) begin
        if (scan_rd) begin
          scan_ptr  <= scan_ptr + CNT_W'(1);
          cmp_idx   <= scan_ptr[IDX_W-1:0];
          cmp_valid <= 1'b1;
        end else begin
          cmp_valid <= 1'b0;
        end
      end

      // strict compare keeps the earliest entry on a tie
      if (cmp_valid) begin
        if (!found || (rd_data.prio < best.prio)) begin
          found    <= 1'b1;
          best     <= rd_data;
          best_idx <= cmp_idx;
        end
      end

      if (cmd.shift_start) begin
        sh_ptr   <= CNT_W'(best_idx) + CNT_W'(1);
        sh_valid <= 1'b0;
      end else if (cmd.shift_step) begin
        if (shift_rd) begin
          sh_ptr   <= sh_ptr + CNT_W'(1);
          sh_waddr <= sh_ptr_m1[IDX_W-1:0];
          sh_valid <= 1'b1;
        end else begin
          sh_valid <= 1'b0;
        end
      end

      if (cmd.commit) begin
        if (do_dispatch) begin
          run_id      <= best.id;
          run_prio    <= best.prio;
          run_valid   <= 1'b1;
          preempted_f <= do_preempt;
          if (!do_preempt) begin
            used <= used_m1;
          end
        end
        run_left <= commit_left;
      end

      if (cmd.load_out) begin
        res_valid <= 1'b1;
      end else if (sched.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      res_running_valid    <= run_valid;
      res_running_id       <= run_valid ? run_id : '0;
      res_running_priority <= run_valid ? run_prio : '0;
      res_running_left     <= run_valid ? run_left : '0;
      res_preempted        <= preempted_f;
      res_retired          <= retired_f;
      res_ready_count      <= COUNT_W'(used);
      res_admit_dropped    <= dropped_f;
    end
  end

  assign sts.scan_done  = (scan_ptr == used) && !cmp_valid;
  assign sts.dispatch   = do_dispatch;
  assign sts.shift_done = (sh_ptr == used) && !sh_valid;
  assign sts.out_free   = !res_valid || sched.ready;

  assign tick.ready = cmd.take;
  assign cfg.ready  = 1'b1;

  assign sched.valid            = res_valid;
  assign sched.running_valid    = res_running_valid;
  assign sched.running_id       = res_running_id;
  assign sched.running_priority = res_running_priority;
  assign sched.running_left     = res_running_left;
  assign sched.preempted        = res_preempted;
  assign sched.retired          = res_retired;
  assign sched.ready_count      = res_ready_count;
  assign sched.admit_dropped    = res_admit_dropped;

endmodule

FILE: rtl/core/preemptive_priority_scheduler.sv
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler
// One tick per transaction: an optional admit to the tail of an eight-entry
// ready table, retirement of a task with no time left, dispatch of the best
// ready task or preemption by a strictly more urgent one (lower priority
// number, earliest entry on a tie), then a saturating decrement of the running
// task's remaining time. The scan, and on a dispatch the compaction, each read
// one entry a cycle through the single read port of the ready table. The next
// tick is taken once the result is in the output register, which holds it
// until the consumer takes it. A full table drops the admit and flags it. The
// quantum register is written on its own channel and resets to three ticks.
// The ready table has no reset: only entries below the fill count are ever
// read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "preemptive_priority_scheduler_macros.svh"

module preemptive_priority_scheduler import pps_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  pps_tick_if.sink    tick,
  pps_sched_if.source sched,
  pps_cfg_if.sink     cfg
);

  cmd_t cmd;
  sts_t sts;

  // sequencer: steps each tick through scan, compaction and commit
  pps_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .tick_valid (tick.valid),
    .sts        (sts),
    .cmd        (cmd)
  );

  // table, running slot, quantum register and result register
  pps_datapath u_datapath (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .sts   (sts),
    .tick  (tick),
    .sched (sched),
    .cfg   (cfg)
  );

  // one tick in flight: ready drops once a transaction is taken
  `PPS_ASSERT_NEXT(a_one_tick, clk, rst, tick.valid && tick.ready,
                   !tick.ready, "tick taken while busy")

  // a preempted task is always replaced, never retired in the same tick
  `PPS_ASSERT_IMPL(a_preempt_runs, clk, rst, sched.valid && sched.preempted,
                   sched.running_valid && !sched.retired, "preemption without a running task")

  // occupancy never passes the table depth
  `PPS_ASSERT_IMPL(a_count_bound, clk, rst, sched.valid,
                   sched.ready_count <= COUNT_W'(READY_DEPTH), "ready count above depth")

  // a loaded result is offered on the next cycle
  `PPS_ASSERT_NEXT(a_result_shown, clk, rst, cmd.load_out, sched.valid, "result not offered")

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the preemptive priority scheduler
// Sends scheduler ticks through directed and random phases at several quantum
// settings, predicts every result from a model of the ready table and the
// running slot, and compares each result field by field in arrival order.
// ----------------------------------------------------------------------------

module testbench import pps_pkg::*; ();

  // Expected content of one result transaction
  typedef struct packed {
    logic               running_valid;
    logic [ID_W-1:0]    running_id;
    logic [PRIO_W-1:0]  running_priority;
    logic [LEFT_W-1:0]  running_left;
    logic               preempted;
    logic               retired;
    logic [COUNT_W-1:0] ready_count;
    logic               admit_dropped;
  } sched_result_t;

  localparam int SHOWN_MAX   = 10;
  localparam int STALL_LIMIT = 1000;
  localparam int SETTLE_CYC  = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pps_tick_if  tick_ch ();
  pps_sched_if sched_ch ();
  pps_cfg_if   cfg_ch ();

  preemptive_priority_scheduler u_dut (
    .clk   (clk),
    .rst   (rst),
    .tick  (tick_ch.sink),
    .sched (sched_ch.source),
    .cfg   (cfg_ch.sink)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Model of the scheduler: ready table in arrival order plus the running slot
  entry_t             rq_table [READY_DEPTH];
  int                 rq_used;
  entry_t             cur_task;
  logic               cur_on;
  logic [QUANT_W-1:0] quantum_now;

  sched_result_t pending_sched [$];
  int            fail_count;
  int            quiet_cycles;
  bit            idle_on;
  bit            stall_on;
  sched_result_t got;

  // Append to the tail; refuse when the table is full
  function automatic bit table_append(entry_t e);
    if (rq_used >= READY_DEPTH) return 1'b0;
    rq_table[rq_used] = e;
    rq_used++;
    return 1'b1;
  endfunction

  // Earliest entry holding the most urgent priority; rq_used when empty
  function automatic int table_best();
    int best;
    best = rq_used;
    for (int i = 0; i < rq_used; i++) begin
      if (best == rq_used || rq_table[i].prio < rq_table[best].prio) best = i;
    end
    return best;
  endfunction

  // Move an entry into the running slot and close the gap behind it
  function automatic void table_take(int idx);
    cur_task = rq_table[idx];
    cur_on   = 1'b1;
    for (int i = idx; i + 1 < rq_used; i++) rq_table[i] = rq_table[i + 1];
    rq_used--;
  endfunction

  // Advance the model by one tick and return the result that it gives
  function automatic sched_result_t schedule_tick(logic m, logic [ID_W-1:0] id,
                                                  logic [PRIO_W-1:0] p);
    sched_result_t     r;
    logic [PRIO_W-1:0] pr;
    entry_t            fresh;
    entry_t            parked;
    int                best;
    r  = '0;
    pr = p;
    // Clamp the requested priority into the legal levels
    if (pr < 1) pr = 1;
    if (pr > PRIO_LEVELS) pr = PRIO_W'(PRIO_LEVELS);
    if (m) begin
      fresh.id   = id;
      fresh.prio = pr;
      fresh.left = quantum_now;
      r.admit_dropped = !table_append(fresh);
    end
    if (cur_on && cur_task.left == 0) begin
      cur_on    = 1'b0;
      r.retired = 1'b1;
    end
    best = table_best();
    if (!cur_on) begin
      if (best < rq_used) table_take(best);
    end else if (best < rq_used && rq_table[best].prio < cur_task.prio) begin
      // Preempt: the old task goes to the tail with its time intact
      parked = cur_task;
      table_take(best);
      void'(table_append(parked));
      r.preempted = 1'b1;
    end
    if (cur_on && cur_task.left != 0) cur_task.left--;
    r.running_valid = cur_on;
    if (cur_on) begin
      r.running_id       = cur_task.id;
      r.running_priority = cur_task.prio;
      r.running_left     = cur_task.left;
    end
    r.ready_count = COUNT_W'(rq_used);
    return r;
  endfunction

  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= SHOWN_MAX) $display("tb: %s", msg);
  endfunction

  function automatic void check_field(string name, logic [7:0] e, logic [7:0] a);
    if (e !== a) note_failure($sformatf("mismatch on %s: expected %0d, got %0d", name, e, a));
  endfunction

  // Check every accepted result against the oldest expectation
  always @(posedge clk) begin
    if (!rst && sched_ch.valid && sched_ch.ready) begin
      if (pending_sched.size() == 0) begin
        note_failure("result transaction with no tick outstanding");
      end else begin
        got = pending_sched.pop_front();
        check_field("running_valid", got.running_valid, sched_ch.running_valid);
        check_field("running_id", got.running_id, sched_ch.running_id);
        check_field("running_priority", got.running_priority, sched_ch.running_priority);
        check_field("running_left", got.running_left, sched_ch.running_left);
        check_field("preempted", got.preempted, sched_ch.preempted);
        check_field("retired", got.retired, sched_ch.retired);
        check_field("ready_count", got.ready_count, sched_ch.ready_count);
        check_field("admit_dropped", got.admit_dropped, sched_ch.admit_dropped);
      end
    end
  end

  // Watchdog: end the run when no channel moves a transaction for too long
  always @(posedge clk) begin
    if ((tick_ch.valid && tick_ch.ready) || (sched_ch.valid && sched_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: watchdog expired with %0d results outstanding", pending_sched.size());
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result consumer: drop ready in random bursts while stalls are enabled
  initial begin
    sched_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    sched_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (stall_on && $urandom_range(0, 5) == 0) begin
        sched_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        sched_ch.ready <= 1'b1;
      end
    end
  end

  // Send one tick; valid stays high after acceptance unless a gap follows
  task automatic send_tick(logic m, logic [ID_W-1:0] id, logic [PRIO_W-1:0] p);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      tick_ch.valid <= 1'b0;
      gap = $urandom_range(1, 8);
      repeat (gap) @(posedge clk);
    end
    tick_ch.valid        <= 1'b1;
    tick_ch.mode         <= m;
    tick_ch.task_id      <= id;
    tick_ch.priority_req <= p;
    do @(posedge clk); while (!tick_ch.ready);
    pending_sched.push_back(schedule_tick(m, id, p));
  endtask

  // Write the quantum once the block has delivered every outstanding result
  task automatic write_quantum(logic [QUANT_W-1:0] q);
    tick_ch.valid <= 1'b0;
    while (pending_sched.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= q;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    quantum_now = q;
  endtask

  task automatic run_ticks(int n, int admit_pct);
    logic m;
    for (int k = 0; k < n; k++) begin
      m = ($urandom_range(0, 99) < admit_pct);
      send_tick(m, ID_W'($urandom), PRIO_W'($urandom_range(0, 7)));
    end
  endtask

  // Empty tick, dispatch, preemption, priority clamp and equal-priority ties
  task automatic test_dispatch_and_preempt();
    send_tick(1'b0, 8'hA5, 3'd0);
    send_tick(1'b1, 8'h00, 3'd7);
    send_tick(1'b1, 8'hFF, 3'd1);
    send_tick(1'b1, 8'h5A, 3'd0);
    send_tick(1'b1, 8'h3C, 3'd1);
    send_tick(1'b1, 8'hC3, 3'd6);
    repeat (6) send_tick(1'b0, 8'h00, 3'd0);
  endtask

  // A task admitted with no time runs with zero left and retires next tick
  task automatic test_zero_quantum();
    write_quantum(8'd0);
    send_tick(1'b1, 8'h81, 3'd3);
    send_tick(1'b1, 8'h7E, 3'd3);
    repeat (3) send_tick(1'b0, 8'hFF, 3'd7);
  endtask

  // Long quantum keeps a low-urgency task running while the table fills
  task automatic test_table_full();
    write_quantum(8'd255);
    for (int k = 0; k < 10; k++) send_tick(1'b1, ID_W'(8'h10 + k), 3'd7);
  endtask

  // Shortest quantum: constant retirement and dispatch
  task automatic test_short_quantum_churn();
    write_quantum(8'd1);
    run_ticks(120, 50);
  endtask

  // Long quantum with heavy admits: drops and preemption dominate
  task automatic test_long_quantum_pressure();
    write_quantum(8'd255);
    run_ticks(110, 75);
  endtask

  // Mid-range quantum with sparse admits, then a random quantum with denser admits
  task automatic test_mixed_quanta();
    write_quantum(QUANT_W'($urandom_range(2, 8)));
    run_ticks(140, 30);
    write_quantum(QUANT_W'($urandom_range(1, 255)));
    run_ticks(150, 60);
  endtask

  // Back-to-back traffic with no idling on either side
  task automatic test_unstalled_finish();
    write_quantum(QUANTUM_RESET);
    idle_on  = 1'b0;
    stall_on = 1'b0;
    run_ticks(110, 50);
  endtask

  initial begin
    tick_ch.valid        <= 1'b0;
    tick_ch.mode         <= 1'b0;
    tick_ch.task_id      <= '0;
    tick_ch.priority_req <= '0;
    cfg_ch.valid         <= 1'b0;
    cfg_ch.data          <= '0;
    rq_used      = 0;
    cur_task     = '0;
    cur_on       = 1'b0;
    quantum_now  = QUANTUM_RESET;
    fail_count   = 0;
    quiet_cycles = 0;
    idle_on      = 1'b1;
    stall_on     = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_dispatch_and_preempt();
    test_zero_quantum();
    test_table_full();
    test_short_quantum_churn();
    test_long_quantum_pressure();
    test_mixed_quanta();
    test_unstalled_finish();

    // Drain the remaining results, then let the block settle
    tick_ch.valid <= 1'b0;
    while (pending_sched.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    if (pending_sched.size() != 0) note_failure("results still outstanding at the end");

    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
